@@ hdl/rlo_pkg.sv @@
package rlo_pkg;

  // Palette and layer geometry
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int LAYER_COUNT   = 4;
  localparam int PAL_WIDTH     = 32;

  // Layer positions in the stack, bottom first
  localparam int LAYER_BG     = 0;
  localparam int LAYER_PENCIL = 1;
  localparam int LAYER_COLOR  = 2;
  localparam int LAYER_FX     = 3;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Blend arithmetic
  localparam int NUM_W    = 26;
  localparam int QUOT_W   = 9;
  localparam int DIV_STGS = QUOT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PENCIL_COLOR      = 3'd0,
    REG_TRANSPARENT_INDEX = 3'd1,
    REG_BG_OPACITY        = 3'd2,
    REG_PENCIL_OPACITY    = 3'd3,
    REG_COLOR_OPACITY     = 3'd4,
    REG_FX_OPACITY        = 3'd5,
    REG_VISIBLE_MASK      = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    OP_COMPOSITE     = 1'b0,
    OP_PALETTE_WRITE = 1'b1
  } op_t;

  typedef struct packed {
    logic [31:0]                  pencil_color;
    logic [7:0]                   transparent_index;
    logic [LAYER_COUNT-1:0][7:0]  opacity;
    logic [LAYER_COUNT-1:0]       visible;
  } cfg_t;

  // One layer of a classified pixel: packed RGBA color, source alpha, skip flag
  typedef struct packed {
    logic [31:0] color;
    logic [7:0]  alpha;
    logic        skip;
  } layer_t;

  typedef layer_t [LAYER_COUNT-1:0] entry_t;

  // Pixel: index 0 red, 1 green, 2 blue, 3 alpha
  typedef logic [3:0][7:0] px_t;

  // Exact x / 255 for x up to an 8 by 8 bit product plus rounding
  function automatic logic [8:0] div255(input logic [15:0] x);
    logic [16:0] y;
    y = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return y[16:8];
  endfunction

endpackage

@@ hdl/rlo_in_if.sv @@
interface rlo_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  bg_index;
  logic [7:0]  pencil_level;
  logic [7:0]  color_index;
  logic [7:0]  fx_index;
  logic [3:0]  present_mask;
  logic [7:0]  palette_addr;
  logic [31:0] palette_word;

  modport source (output valid, op, bg_index, pencil_level, color_index, fx_index,
                  present_mask, palette_addr, palette_word, input ready);
  modport sink (input valid, op, bg_index, pencil_level, color_index, fx_index,
                present_mask, palette_addr, palette_word, output ready);
endinterface

@@ hdl/rlo_out_if.sv @@
interface rlo_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

@@ hdl/rlo_ram.sv @@
module rlo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/rlo_front.sv @@
module rlo_front (
  input  logic                     clk,
  input  logic                     rst_n,
  rlo_in_if.sink                   in_ch,
  input  rlo_pkg::cfg_t            cfg,
  input  logic [rlo_pkg::QUEUE_AW:0] q_count,
  output logic                     push,
  output rlo_pkg::entry_t          push_data
);
  import rlo_pkg::*;

  logic                accept;
  logic                pal_we;
  logic [QUEUE_AW:0]   fill;
  logic                front_v_r;
  logic [7:0]          bg_idx_r;
  logic [7:0]          color_idx_r;
  logic [7:0]          fx_idx_r;
  logic [7:0]          level_r;
  logic [3:0]          pres_r;
  logic [PAL_WIDTH-1:0] bg_rd;
  logic [PAL_WIDTH-1:0] color_rd;
  logic [PAL_WIDTH-1:0] fx_rd;

  // Take an item while the queue has room for it and the one in flight
  assign fill        = q_count + {{QUEUE_AW{1'b0}}, front_v_r};
  assign in_ch.ready = (fill < (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  assign pal_we      = accept && (op_t'(in_ch.op) == OP_PALETTE_WRITE);

  // Palette copies: one read port per palette layer, all written alike
  rlo_ram #(.WIDTH(PAL_WIDTH), .DEPTH(PALETTE_DEPTH)) u_ram_bg (
    .clk(clk), .we(pal_we), .waddr(in_ch.palette_addr[PAL_AW-1:0]),
    .wdata(in_ch.palette_word), .raddr(in_ch.bg_index[PAL_AW-1:0]), .rdata(bg_rd)
  );
  rlo_ram #(.WIDTH(PAL_WIDTH), .DEPTH(PALETTE_DEPTH)) u_ram_color (
    .clk(clk), .we(pal_we), .waddr(in_ch.palette_addr[PAL_AW-1:0]),
    .wdata(in_ch.palette_word), .raddr(in_ch.color_index[PAL_AW-1:0]), .rdata(color_rd)
  );
  rlo_ram #(.WIDTH(PAL_WIDTH), .DEPTH(PALETTE_DEPTH)) u_ram_fx (
    .clk(clk), .we(pal_we), .waddr(in_ch.palette_addr[PAL_AW-1:0]),
    .wdata(in_ch.palette_word), .raddr(in_ch.fx_index[PAL_AW-1:0]), .rdata(fx_rd)
  );

  // Hold composite items while the palette read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= accept && (op_t'(in_ch.op) == OP_COMPOSITE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bg_idx_r    <= in_ch.bg_index;
      color_idx_r <= in_ch.color_index;
      fx_idx_r    <= in_ch.fx_index;
      level_r     <= in_ch.pencil_level;
      pres_r      <= in_ch.present_mask;
    end
  end

  // Classify each layer: pick color and alpha, flag layers that drop out
  always_comb begin
    push_data[LAYER_BG].color     = bg_rd;
    push_data[LAYER_BG].alpha     = bg_rd[31:24];
    push_data[LAYER_BG].skip      = !cfg.visible[LAYER_BG] || !pres_r[LAYER_BG] ||
                                    (bg_idx_r == cfg.transparent_index);
    push_data[LAYER_PENCIL].color = cfg.pencil_color;
    push_data[LAYER_PENCIL].alpha = level_r;
    push_data[LAYER_PENCIL].skip  = !cfg.visible[LAYER_PENCIL] || !pres_r[LAYER_PENCIL] ||
                                    (level_r == 8'd0);
    push_data[LAYER_COLOR].color  = color_rd;
    push_data[LAYER_COLOR].alpha  = color_rd[31:24];
    push_data[LAYER_COLOR].skip   = !cfg.visible[LAYER_COLOR] || !pres_r[LAYER_COLOR] ||
                                    (color_idx_r == cfg.transparent_index);
    push_data[LAYER_FX].color     = fx_rd;
    push_data[LAYER_FX].alpha     = fx_rd[31:24];
    push_data[LAYER_FX].skip      = !cfg.visible[LAYER_FX] || !pres_r[LAYER_FX] ||
                                    (fx_idx_r == cfg.transparent_index);
  end

  assign push = front_v_r;

  chk_composite_push: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op_t'(in_ch.op) == OP_COMPOSITE)) |=> push)
    else $error("composite transfer did not reach the queue");
  chk_write_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (!accept || (op_t'(in_ch.op) == OP_PALETTE_WRITE)) |=> !push)
    else $error("queue push without a composite transfer");
  chk_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (fill < (QUEUE_AW+1)'(QUEUE_DEPTH)))
    else $error("transfer taken with the queue full");
endmodule

@@ hdl/rlo_fifo.sv @@
module rlo_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  rlo_pkg::entry_t            push_data,
  input  logic                       pop,
  output rlo_pkg::entry_t            pop_data,
  output logic [rlo_pkg::QUEUE_AW:0] count
);
  import rlo_pkg::*;

  entry_t              mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;
  logic [QUEUE_AW:0]   count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign count    = count_r;

  chk_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ((count_r < (QUEUE_AW+1)'(QUEUE_DEPTH)) || pop))
    else $error("queue push while full");
  chk_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue pop while empty");
  chk_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && pop) |=> $stable(count_r))
    else $error("occupancy moved on a push with pop");
endmodule

@@ hdl/rlo_layer.sv @@
module rlo_layer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  rlo_pkg::px_t     in_px,
  input  rlo_pkg::entry_t  in_ent,
  input  rlo_pkg::layer_t  lyr,
  input  logic [7:0]       opacity,
  output logic             out_v,
  output rlo_pkg::px_t     out_px,
  output rlo_pkg::entry_t  out_ent
);
  import rlo_pkg::*;

  // Stage 1: alpha times opacity
  logic               v1_r;
  px_t                px1_r;
  entry_t             ent1_r;
  logic [2:0][7:0]    c1_r;
  logic [15:0]        prod1_r;
  logic               skip1_r;
  // Stage 2: scaled alpha
  logic               v2_r;
  px_t                px2_r;
  entry_t             ent2_r;
  logic [2:0][7:0]    c2_r;
  logic [7:0]         a2_r;
  logic               skip2_r;
  logic [8:0]         a_q;
  // Stage 3: first products
  logic               v3_r;
  px_t                px3_r;
  entry_t             ent3_r;
  logic [7:0]         a3_r;
  logic [7:0]         inv3_r;
  logic [15:0]        t3_r;
  logic [2:0][15:0]   ca3_r;
  logic [2:0][15:0]   dd3_r;
  logic               skip3_r;
  logic [7:0]         inv2;
  // Stage 4: out alpha and weighted terms
  logic               v4_r;
  px_t                px4_r;
  entry_t             ent4_r;
  logic [7:0]         oa4_r;
  logic [2:0][23:0]   cw4_r;
  logic [2:0][23:0]   p4_r;
  logic               skip4_r;
  logic [8:0]         oa_q;
  // Stage 5: numerators; then restoring divider, one quotient bit per stage
  logic [15:0]        den5;
  logic [2:0][NUM_W-1:0] num5;
  logic [2:0]         ovf5;
  logic               dv_r   [DIV_STGS+1];
  px_t                dpx_r  [DIV_STGS+1];
  entry_t             dent_r [DIV_STGS+1];
  logic [15:0]        dden_r [DIV_STGS+1];
  logic [7:0]         doa_r  [DIV_STGS+1];
  logic               dskip_r[DIV_STGS+1];
  logic [2:0]         dovf_r [DIV_STGS+1];
  logic [2:0][NUM_W-1:0]  drem_r [DIV_STGS+1];
  logic [2:0][QUOT_W-1:0] dq_r   [DIV_STGS+1];

  assign a_q  = div255(prod1_r);
  assign inv2 = 8'd255 - a2_r;
  assign oa_q = div255(t3_r + 16'd127);

  // Stages 1 to 4
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r   <= in_px;
      ent1_r  <= in_ent;
      c1_r    <= lyr.color[23:0];
      prod1_r <= {8'd0, lyr.alpha} * {8'd0, opacity};
      skip1_r <= lyr.skip;

      px2_r   <= px1_r;
      ent2_r  <= ent1_r;
      c2_r    <= c1_r;
      a2_r    <= a_q[7:0];
      skip2_r <= skip1_r;

      px3_r   <= px2_r;
      ent3_r  <= ent2_r;
      a3_r    <= a2_r;
      inv3_r  <= inv2;
      t3_r    <= {8'd0, px2_r[3]} * {8'd0, inv2};
      skip3_r <= skip2_r;
      for (int k = 0; k < 3; k++) begin
        ca3_r[k] <= {8'd0, c2_r[k]} * {8'd0, a2_r};
        dd3_r[k] <= {8'd0, px2_r[k]} * {8'd0, px2_r[3]};
      end

      px4_r   <= px3_r;
      ent4_r  <= ent3_r;
      oa4_r   <= a3_r + oa_q[7:0];
      skip4_r <= skip3_r || (a3_r == 8'd0);
      for (int k = 0; k < 3; k++) begin
        cw4_r[k] <= {ca3_r[k], 8'd0} - {8'd0, ca3_r[k]};
        p4_r[k]  <= {8'd0, dd3_r[k]} * {16'd0, inv3_r};
      end
    end
  end

  // Numerators with rounding, and the shared denominator
  always_comb begin
    den5 = {oa4_r, 8'd0} - {8'd0, oa4_r};
    for (int k = 0; k < 3; k++) begin
      num5[k] = NUM_W'(cw4_r[k]) + NUM_W'(p4_r[k]) + NUM_W'(den5[15:1]);
      ovf5[k] = (num5[k] >= NUM_W'({den5, {QUOT_W{1'b0}}}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dpx_r[0]   <= px4_r;
      dent_r[0]  <= ent4_r;
      dden_r[0]  <= den5;
      doa_r[0]   <= oa4_r;
      dskip_r[0] <= skip4_r;
      dovf_r[0]  <= ovf5;
      drem_r[0]  <= num5;
      dq_r[0]    <= '0;
    end
  end

  for (genvar j = 0; j < DIV_STGS; j++) begin : g_div
    localparam int BIT = QUOT_W - 1 - j;
    logic [NUM_W-1:0]              sub;
    logic [2:0][NUM_W-1:0]         rem_nxt;
    logic [2:0][QUOT_W-1:0]        q_nxt;

    // Try one shifted subtract per channel
    always_comb begin
      sub = NUM_W'(dden_r[j]) << BIT;
      for (int k = 0; k < 3; k++) begin
        rem_nxt[k] = drem_r[j][k];
        q_nxt[k]   = dq_r[j][k];
        if (drem_r[j][k] >= sub) begin
          rem_nxt[k]    = drem_r[j][k] - sub;
          q_nxt[k][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_r[j+1] <= dv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dpx_r[j+1]   <= dpx_r[j];
        dent_r[j+1]  <= dent_r[j];
        dden_r[j+1]  <= dden_r[j];
        doa_r[j+1]   <= doa_r[j];
        dskip_r[j+1] <= dskip_r[j];
        dovf_r[j+1]  <= dovf_r[j];
        drem_r[j+1]  <= rem_nxt;
        dq_r[j+1]    <= q_nxt;
      end
    end
  end

  // Saturate the channels, or pass the pixel through for a dropped layer
  always_comb begin
    out_px = dpx_r[DIV_STGS];
    if (!dskip_r[DIV_STGS]) begin
      for (int k = 0; k < 3; k++) begin
        out_px[k] = (dovf_r[DIV_STGS][k] || dq_r[DIV_STGS][k][QUOT_W-1]) ?
                    8'd255 : dq_r[DIV_STGS][k][7:0];
      end
      out_px[3] = doa_r[DIV_STGS];
    end
  end

  assign out_v   = dv_r[DIV_STGS];
  assign out_ent = dent_r[DIV_STGS];

  chk_alpha_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !skip4_r) |-> (oa4_r >= px4_r[3]))
    else $error("blend lowered the destination alpha");
  chk_live_den: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r[0] && !dskip_r[0]) |-> (dden_r[0] != 16'd0))
    else $error("zero divisor on a blended layer");
  chk_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(dv_r[DIV_STGS]))
    else $error("layer pipeline moved while stalled");
endmodule

@@ hdl/rlo_back.sv @@
module rlo_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rlo_pkg::cfg_t              cfg,
  input  logic [rlo_pkg::QUEUE_AW:0] q_count,
  output logic                       pop,
  input  rlo_pkg::entry_t            pop_data,
  rlo_out_if.source                  out_ch
);
  import rlo_pkg::*;

  logic   en;
  logic   v   [LAYER_COUNT+1];
  px_t    px  [LAYER_COUNT+1];
  entry_t ent [LAYER_COUNT+1];
  logic   out_v_r;
  px_t    out_px_r;

  // Whole chain advances unless a finished pixel is waiting
  assign en  = !out_v_r || out_ch.ready;
  assign pop = en && (q_count != '0);

  // Start from transparent black
  assign v[0]   = pop;
  assign px[0]  = '0;
  assign ent[0] = pop_data;

  for (genvar i = 0; i < LAYER_COUNT; i++) begin : g_layer
    rlo_layer u_layer (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_v    (v[i]),
      .in_px   (px[i]),
      .in_ent  (ent[i]),
      .lyr     (ent[i][i]),
      .opacity (cfg.opacity[i]),
      .out_v   (v[i+1]),
      .out_px  (px[i+1]),
      .out_ent (ent[i+1])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v[LAYER_COUNT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_px_r <= px[LAYER_COUNT];
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.out_red   = out_px_r[0];
  assign out_ch.out_green = out_px_r[1];
  assign out_ch.out_blue  = out_px_r[2];
  assign out_ch.out_alpha = out_px_r[3];

  chk_pop_gated: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> en)
    else $error("queue popped during an output stall");
  chk_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> (out_v_r && $stable(out_px_r)))
    else $error("waiting pixel overwritten");
  chk_ent_head: assert property (@(posedge clk) disable iff (!rst_n)
    !pop |=> !v[0] || (q_count != '0))
    else $error("chain fed from an empty queue");
endmodule

@@ hdl/rgba_layer_over_compositor.sv @@
// Four-layer RGBA over compositor. Each composite item blends background, pencil,
// color and effects layers over transparent black and returns one pixel; a palette
// write item stores one 32-bit entry (red in bits 7:0, alpha in 31:24) and returns
// nothing. One item is taken per clock while the queue has room: the front end reads three
// palette copies in parallel and classifies the layers, a four-entry queue decouples it
// from the blend chain, and each layer is a 14-stage pipeline whose nine-stage restoring
// divider sets the depth. The output register and the queue let new items enter while
// a result waits. Configuration registers are written by index on cfg_we and should
// change only when idle.
module rgba_layer_over_compositor (
  input  logic                             clk,
  input  logic                             rst_n,
  rlo_in_if.sink                           in_ch,
  rlo_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [rlo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlo_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import rlo_pkg::*;

  cfg_t              cfg_r;
  logic              push;
  logic              pop;
  entry_t            push_data;
  entry_t            pop_data;
  logic [QUEUE_AW:0] q_count;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pencil_color      <= '0;
      cfg_r.transparent_index <= '0;
      cfg_r.opacity           <= {LAYER_COUNT{8'd255}};
      cfg_r.visible           <= '1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PENCIL_COLOR:      cfg_r.pencil_color           <= cfg_wdata[31:0];
        REG_TRANSPARENT_INDEX: cfg_r.transparent_index      <= cfg_wdata[7:0];
        REG_BG_OPACITY:        cfg_r.opacity[LAYER_BG]      <= cfg_wdata[7:0];
        REG_PENCIL_OPACITY:    cfg_r.opacity[LAYER_PENCIL]  <= cfg_wdata[7:0];
        REG_COLOR_OPACITY:     cfg_r.opacity[LAYER_COLOR]   <= cfg_wdata[7:0];
        REG_FX_OPACITY:        cfg_r.opacity[LAYER_FX]      <= cfg_wdata[7:0];
        REG_VISIBLE_MASK:      cfg_r.visible                <= cfg_wdata[LAYER_COUNT-1:0];
        default: ;
      endcase
    end
  end

  rlo_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  rlo_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .count     (q_count)
  );

  rlo_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_count  (q_count),
    .pop      (pop),
    .pop_data (pop_data),
    .out_ch   (out_ch)
  );
endmodule

@@ tb/rlo_blend_checker.sv @@
`timescale 1ns / 100ps

module rlo_blend_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  rlo_in_if                              in_ch,
  rlo_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [rlo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlo_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             pixels_due
);
  import rlo_pkg::*;

  // Shadow of the block's registers and palette
  logic [31:0] pen_color;
  logic [7:0]  clear_idx;
  logic [7:0]  layer_opac [LAYER_COUNT];
  logic [3:0]  vis_mask;
  logic [31:0] palette_copy [PALETTE_DEPTH];

  px_t expected_pixels [$];

  // Blend one layer over the running pixel with the rounded "over" rule
  function automatic px_t over_layer(input px_t dst, input logic [31:0] color,
                                     input int unsigned a);
    px_t         res;
    int unsigned da, inv, oa;
    longint unsigned den, num, v;
    res = dst;
    da  = dst[3];
    inv = 255 - a;
    oa  = a + (da * inv + 127) / 255;
    den = longint'(oa) * 255;
    if (a == 0 || den == 0) return res;
    for (int k = 0; k < 3; k++) begin
      num = longint'(color[8*k +: 8]) * a * 255 + longint'(dst[k]) * da * inv + den / 2;
      v = num / den;
      res[k] = (v > 255) ? 8'd255 : v[7:0];
    end
    res[3] = (oa > 255) ? 8'd255 : oa[7:0];
    return res;
  endfunction

  // Composite the four layers of one pixel, bottom first
  function automatic px_t composite_pixel(input logic [7:0] idx [LAYER_COUNT],
                                          input logic [3:0] present);
    px_t         px;
    logic [31:0] color;
    int unsigned a;
    px = '0;
    for (int layer = 0; layer < LAYER_COUNT; layer++) begin
      if (!vis_mask[layer] || !present[layer]) continue;
      if (layer == LAYER_PENCIL) begin
        if (idx[layer] == 0) continue;
        color = pen_color;
        a = idx[layer];
      end else begin
        if (idx[layer] == clear_idx) continue;
        color = palette_copy[idx[layer] % PALETTE_DEPTH];
        a = color[31:24];
      end
      a = a * layer_opac[layer] / 255;
      px = over_layer(px, color, a);
    end
    return px;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [7:0] idx [LAYER_COUNT];
    px_t        want;
    if (!rst_n) begin
      pen_color = '0;
      clear_idx = '0;
      for (int i = 0; i < LAYER_COUNT; i++) layer_opac[i] = 8'd255;
      vis_mask = 4'hF;
      expected_pixels.delete();
      fail_count = 0;
      pixels_due = 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_PENCIL_COLOR:      pen_color = cfg_wdata;
          REG_TRANSPARENT_INDEX: clear_idx = cfg_wdata[7:0];
          REG_BG_OPACITY:        layer_opac[LAYER_BG] = cfg_wdata[7:0];
          REG_PENCIL_OPACITY:    layer_opac[LAYER_PENCIL] = cfg_wdata[7:0];
          REG_COLOR_OPACITY:     layer_opac[LAYER_COLOR] = cfg_wdata[7:0];
          REG_FX_OPACITY:        layer_opac[LAYER_FX] = cfg_wdata[7:0];
          REG_VISIBLE_MASK:      vis_mask = cfg_wdata[3:0];
          default: ;
        endcase
      end
      // Predict on each input transfer
      if (in_ch.valid && in_ch.ready) begin
        if (op_t'(in_ch.op) == OP_PALETTE_WRITE) begin
          palette_copy[in_ch.palette_addr % PALETTE_DEPTH] = in_ch.palette_word;
        end else begin
          idx[LAYER_BG]     = in_ch.bg_index;
          idx[LAYER_PENCIL] = in_ch.pencil_level;
          idx[LAYER_COLOR]  = in_ch.color_index;
          idx[LAYER_FX]     = in_ch.fx_index;
          expected_pixels.push_back(composite_pixel(idx, in_ch.present_mask));
        end
      end
      // Compare each result transfer with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("pixels waiting", 0, 1);
        end else begin
          want = expected_pixels.pop_front();
          if (out_ch.out_red !== want[0]) report_mismatch("red", out_ch.out_red, want[0]);
          if (out_ch.out_green !== want[1])
            report_mismatch("green", out_ch.out_green, want[1]);
          if (out_ch.out_blue !== want[2]) report_mismatch("blue", out_ch.out_blue, want[2]);
          if (out_ch.out_alpha !== want[3])
            report_mismatch("alpha", out_ch.out_alpha, want[3]);
        end
      end
      pixels_due = expected_pixels.size();
    end
  end

endmodule

@@ tb/rgba_layer_over_compositor_test.sv @@
`timescale 1ns / 100ps

module rgba_layer_over_compositor_test;
  import rlo_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 100;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pixels_due;
  int                    cycle_count = 0;
  int                    burst_left;
  int                    stall_mode;
  logic [7:0]            cur_clear;

  rlo_in_if  in_ch ();
  rlo_out_if out_ch ();

  rgba_layer_over_compositor dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  rlo_blend_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pixels_due(pixels_due)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Receiver stalls: switch at random among four ready patterns
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (cycle_count % 8 != 0);
      endcase
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Drive one item and hold it until the transfer
  task automatic push_item(input logic op, input logic [7:0] bg, input logic [7:0] pen,
                           input logic [7:0] col, input logic [7:0] fx,
                           input logic [3:0] present, input logic [7:0] addr,
                           input logic [31:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 20);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.bg_index     <= bg;
    in_ch.pencil_level <= pen;
    in_ch.color_index  <= col;
    in_ch.fx_index     <= fx;
    in_ch.present_mask <= present;
    in_ch.palette_addr <= addr;
    in_ch.palette_word <= word;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  task automatic push_pixel(input logic [7:0] bg, input logic [7:0] pen,
                            input logic [7:0] col, input logic [7:0] fx,
                            input logic [3:0] present);
    push_item(OP_COMPOSITE, bg, pen, col, fx, present, 8'($urandom), $urandom);
  endtask

  task automatic push_entry(input logic [7:0] addr, input logic [31:0] word);
    push_item(OP_PALETTE_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              4'($urandom), addr, word);
  endtask

  // Drop valid and hold until every pixel is out and the pipe is empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pixels_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] pen, input logic [7:0] clr,
                            input logic [7:0] bg_o, input logic [7:0] pen_o,
                            input logic [7:0] col_o, input logic [7:0] fx_o,
                            input logic [3:0] vis);
    write_reg(REG_PENCIL_COLOR, pen);
    write_reg(REG_TRANSPARENT_INDEX, ({$urandom} & 32'hFFFF_FF00) | {24'd0, clr});
    write_reg(REG_BG_OPACITY, {24'd0, bg_o});
    write_reg(REG_PENCIL_OPACITY, {24'd0, pen_o});
    write_reg(REG_COLOR_OPACITY, {24'd0, col_o});
    write_reg(REG_FX_OPACITY, {24'd0, fx_o});
    write_reg(REG_VISIBLE_MASK, {28'd0, vis});
    cfg_we <= 1'b0;
    cur_clear = clr;
  endtask

  // Pick an index, often the transparent one
  function automatic logic [7:0] pick_index();
    return ($urandom_range(0, 4) == 0) ? cur_clear : 8'($urandom);
  endfunction

  initial begin
    logic [31:0] word;
    in_ch.valid = 1'b0;
    in_ch.op = OP_COMPOSITE;
    in_ch.bg_index = '0;
    in_ch.pencil_level = '0;
    in_ch.color_index = '0;
    in_ch.fx_index = '0;
    in_ch.present_mask = '0;
    in_ch.palette_addr = '0;
    in_ch.palette_word = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    burst_left = 0;
    cur_clear = 8'd0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load every palette entry so no read hits an unwritten one
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      case (i)
        0:       word = 32'h00FF_FFFF;
        1:       word = 32'hFFFF_FFFF;
        2:       word = 32'hFF00_0000;
        3:       word = 32'h80FF_8040;
        255:     word = 32'h01FF_FFFF;
        default: word = $urandom;
      endcase
      push_entry(8'(i), word);
    end

    // Directed pixels under reset settings, then under three other settings
    push_pixel(8'd1, 8'd0, 8'd2, 8'd3, 4'hF);
    push_pixel(8'd0, 8'd0, 8'd0, 8'd0, 4'hF);
    push_pixel(8'd1, 8'd255, 8'd255, 8'd1, 4'hF);
    push_pixel(8'd255, 8'd128, 8'd3, 8'd2, 4'hF);
    push_pixel(8'd3, 8'd1, 8'd255, 8'd3, 4'hF);
    push_pixel(8'd1, 8'd255, 8'd2, 8'd3, 4'h0);
    push_pixel(8'd1, 8'd255, 8'd2, 8'd3, 4'h1);
    push_pixel(8'd1, 8'd255, 8'd2, 8'd3, 4'h2);
    push_pixel(8'd1, 8'd255, 8'd2, 8'd3, 4'h4);
    push_pixel(8'd1, 8'd255, 8'd2, 8'd3, 4'h8);
    push_entry(8'd255, 32'hFF12_3456);
    push_pixel(8'd2, 8'd64, 8'd255, 8'd255, 4'hF);
    drain();
    set_config(32'hFFFF_FFFF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 4'hF);
    push_pixel(8'd255, 8'd200, 8'd1, 8'd3, 4'hF);
    push_pixel(8'd0, 8'd255, 8'd0, 8'd255, 4'hF);
    drain();
    set_config(32'h0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'hF);
    push_pixel(8'd1, 8'd255, 8'd3, 8'd2, 4'hF);
    drain();
    set_config(32'h80FF_00FF, 8'd7, 8'd255, 8'd255, 8'd255, 8'd255, 4'h0);
    push_pixel(8'd1, 8'd255, 8'd3, 8'd2, 4'hF);
    drain();

    // Random phases across settings
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_config(32'hFFFF_FFFF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 4'hF);
        1: set_config(32'h0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'hF);
        2: set_config($urandom, 8'($urandom), 8'd128, 8'd200, 8'd60, 8'd255, 4'hF);
        3: set_config($urandom, 8'($urandom), 8'd255, 8'd1, 8'd255, 8'd1, 4'hA);
        4: begin
          write_reg(cfg_reg_t'(3'd7), $urandom);
          set_config($urandom, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 4'($urandom));
        end
        default: set_config($urandom, 8'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom), 4'($urandom));
      endcase
      for (int n = 0; n < 190; n++) begin
        if (phase == 2 && n == 95) drain();
        if ($urandom_range(0, 6) == 0) begin
          push_entry(8'($urandom), $urandom);
        end else begin
          push_pixel(pick_index(), ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom),
                     pick_index(), pick_index(),
                     ($urandom_range(0, 2) == 0) ? 4'hF : 4'($urandom));
        end
      end
      drain();
    end

    if (fail_count == 0 && pixels_due == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/rlo_pkg.sv
hdl/rlo_in_if.sv
hdl/rlo_out_if.sv
hdl/rlo_ram.sv
hdl/rlo_front.sv
hdl/rlo_fifo.sv
hdl/rlo_layer.sv
hdl/rlo_back.sv
hdl/rgba_layer_over_compositor.sv
tb/rlo_blend_checker.sv
tb/rgba_layer_over_compositor_test.sv
